// ===== rtl/core/base32_stream_encoder_macros.svh =====
// Assertion macros used by the base32 stream encoder checker.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define B32SE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define B32SE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/b32se_pkg.sv =====
// Types, character codes and the group-to-character map of the base32 stream encoder.
`timescale 1ns / 1ps

package b32se_pkg;

   localparam int MAX_SYMBOLS = 4;

   typedef logic [6:0] symbol_type;
   typedef logic [4:0] group_type;

   localparam symbol_type ASCII_A     = 7'h41;
   localparam symbol_type ASCII_0     = 7'h30;
   localparam symbol_type SYM_NEWLINE = 7'd10;
   localparam group_type  DIGIT_START = 5'd26;

   // All characters that one byte produces, in output order.
   typedef struct packed {
      symbol_type [MAX_SYMBOLS-1:0] syms;
      logic [2:0]                   count;
   } entry_type;

   function automatic symbol_type group_to_symbol(input group_type g);
      symbol_type result;
      if (g < DIGIT_START) begin
         result = ASCII_A + {2'b00, g};
      end else begin
         result = ASCII_0 + {2'b00, g - DIGIT_START};
      end
      return result;
   endfunction

endpackage

// ===== rtl/core/b32se_if.sv =====
// Valid/ready channel interfaces for the byte input and the character output.
`timescale 1ns / 1ps

interface b32se_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32se_rsp_if;
   logic                 valid;
   logic                 ready;
   b32se_pkg::symbol_type symbol;
   logic                 run_last;

   modport source (output valid, output symbol, output run_last, input ready);
   modport sink   (input valid, input symbol, input run_last, output ready);
endinterface

// ===== rtl/core/base32_stream_encoder.sv =====
// Streaming base32-variant encoder: bytes in, ASCII characters and newlines out.
`timescale 1ns / 1ps
//
//  channel  direction  payload                   item
//  req_if   in         data_byte[7:0], final_byte one raw byte
//  rsp_if   out        symbol[6:0], run_last      one ASCII character
//
// A byte is encoded in the cycle it is accepted and yields one to four characters,
// which are held in a result slot and leave one per cycle while rsp_if is ready.
// Two result slots let a byte enter while the previous one drains, so the sustained
// byte rate is set by each byte's character count (one or two, up to four at a line
// end or on the final byte) and the one-character-per-cycle result port.
// Synchronous reset clears the carried bits and the line count and empties both slots.
// A stall on rsp_if holds the character; req_if stalls only when both slots are full.

module base32_stream_encoder #(
   parameter int LINE_BYTES = 45
) (
   input  logic               clock,
   input  logic               reset,
   b32se_req_if.sink          req_if,
   b32se_rsp_if.source        rsp_if
);

   localparam logic [5:0] LINE_LIMIT = 6'(LINE_BYTES);

   logic [3:0] spare_bits_ff,      spare_bits_in;
   logic [2:0] spare_count_ff,     spare_count_in;
   logic [5:0] line_bytes_seen_ff, line_bytes_seen_in;

   b32se_pkg::entry_type slot_ff [2];
   logic [1:0] slot_count_ff, slot_count_in;
   logic       wr_ptr_ff,     wr_ptr_in;
   logic       rd_ptr_ff,     rd_ptr_in;
   logic [1:0] pos_ff,        pos_in;

   logic                 accept;
   logic                 take;
   logic                 last_of_run;
   b32se_pkg::entry_type cur_entry;
   b32se_pkg::entry_type new_entry;

   b32se_pkg::group_type first_group;
   b32se_pkg::group_type second_group;
   b32se_pkg::group_type pad_group;
   logic                 two_groups;
   logic [3:0]           left_bits;
   logic [2:0]           left_count;
   logic [5:0]           line_next;
   logic                 flush;
   logic [2:0]           k;

   assign accept = req_if.valid && req_if.ready;
   assign take   = rsp_if.valid && rsp_if.ready;

   assign req_if.ready = (slot_count_ff != 2'd2);

   assign cur_entry       = slot_ff[rd_ptr_ff];
   assign last_of_run     = (({1'b0, pos_ff} + 3'd1) == cur_entry.count);
   assign rsp_if.valid    = (slot_count_ff != 2'd0);
   assign rsp_if.symbol   = cur_entry.syms[pos_ff];
   assign rsp_if.run_last = last_of_run;

   // Split the carried bits plus the new byte, MSB first, into 5-bit groups.
   always_comb begin
      first_group  = '0;
      second_group = '0;
      two_groups   = 1'b0;
      left_bits    = '0;
      left_count   = '0;
      unique case (spare_count_ff)
         3'd0: begin
            first_group = req_if.data_byte[7:3];
            left_bits   = {1'b0, req_if.data_byte[2:0]};
            left_count  = 3'd3;
         end
         3'd1: begin
            first_group = {spare_bits_ff[0], req_if.data_byte[7:4]};
            left_bits   = req_if.data_byte[3:0];
            left_count  = 3'd4;
         end
         3'd2: begin
            first_group  = {spare_bits_ff[1:0], req_if.data_byte[7:5]};
            second_group = req_if.data_byte[4:0];
            two_groups   = 1'b1;
         end
         3'd3: begin
            first_group  = {spare_bits_ff[2:0], req_if.data_byte[7:6]};
            second_group = req_if.data_byte[5:1];
            two_groups   = 1'b1;
            left_bits    = {3'b000, req_if.data_byte[0]};
            left_count   = 3'd1;
         end
         default: begin
            // Four carried bits; larger counts never occur and are treated the same.
            first_group  = {spare_bits_ff[3:0], req_if.data_byte[7]};
            second_group = req_if.data_byte[6:2];
            two_groups   = 1'b1;
            left_bits    = {2'b00, req_if.data_byte[1:0]};
            left_count   = 3'd2;
         end
      endcase
   end

   // Leftover bits are padded with zeros on the right into a final group.
   always_comb begin
      unique case (left_count)
         3'd1:    pad_group = {left_bits[0],   4'b0000};
         3'd2:    pad_group = {left_bits[1:0], 3'b000};
         3'd3:    pad_group = {left_bits[2:0], 2'b00};
         3'd4:    pad_group = {left_bits[3:0], 1'b0};
         default: pad_group = '0;
      endcase
   end

   assign line_next = line_bytes_seen_ff + 6'd1;
   assign flush     = (line_next >= LINE_LIMIT) || req_if.final_byte;

   always_comb begin
      new_entry = '0;
      k         = 3'd0;
      new_entry.syms[k[1:0]] = b32se_pkg::group_to_symbol(first_group);
      k = k + 3'd1;
      if (two_groups) begin
         new_entry.syms[k[1:0]] = b32se_pkg::group_to_symbol(second_group);
         k = k + 3'd1;
      end
      if (flush && (left_count != 3'd0)) begin
         new_entry.syms[k[1:0]] = b32se_pkg::group_to_symbol(pad_group);
         k = k + 3'd1;
      end
      if (flush) begin
         new_entry.syms[k[1:0]] = b32se_pkg::SYM_NEWLINE;
         k = k + 3'd1;
      end
      new_entry.count = k;
   end

   always_comb begin
      spare_bits_in      = spare_bits_ff;
      spare_count_in     = spare_count_ff;
      line_bytes_seen_in = line_bytes_seen_ff;
      wr_ptr_in          = wr_ptr_ff;
      rd_ptr_in          = rd_ptr_ff;
      pos_in             = pos_ff;
      slot_count_in      = slot_count_ff;
      if (accept) begin
         wr_ptr_in = ~wr_ptr_ff;
         if (flush) begin
            spare_bits_in      = '0;
            spare_count_in     = '0;
            line_bytes_seen_in = '0;
         end else begin
            spare_bits_in      = left_bits;
            spare_count_in     = left_count;
            line_bytes_seen_in = line_next;
         end
      end
      if (take) begin
         if (last_of_run) begin
            rd_ptr_in = ~rd_ptr_ff;
            pos_in    = '0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      slot_count_in = slot_count_ff + {1'b0, accept} - {1'b0, take && last_of_run};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spare_bits_ff      <= '0;
         spare_count_ff     <= '0;
         line_bytes_seen_ff <= '0;
         wr_ptr_ff          <= 1'b0;
         rd_ptr_ff          <= 1'b0;
         pos_ff             <= '0;
         slot_count_ff      <= '0;
      end else begin
         spare_bits_ff      <= spare_bits_in;
         spare_count_ff     <= spare_count_in;
         line_bytes_seen_ff <= line_bytes_seen_in;
         wr_ptr_ff          <= wr_ptr_in;
         rd_ptr_ff          <= rd_ptr_in;
         pos_ff             <= pos_in;
         slot_count_ff      <= slot_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== rtl/core/b32se_checker.sv =====
// Port-level checks for the base32 stream encoder, bound to its top level.
`timescale 1ns / 1ps
`include "base32_stream_encoder_macros.svh"

module b32se_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input b32se_pkg::symbol_type rsp_symbol,
   input logic                  rsp_run_last
);

   logic is_letter;
   logic is_digit;
   logic is_newline;

   assign is_letter  = (rsp_symbol >= b32se_pkg::ASCII_A) &&
                       (rsp_symbol <= (b32se_pkg::ASCII_A + 7'd25));
   assign is_digit   = (rsp_symbol >= b32se_pkg::ASCII_0) &&
                       (rsp_symbol <= (b32se_pkg::ASCII_0 + 7'd5));
   assign is_newline = (rsp_symbol == b32se_pkg::SYM_NEWLINE);

   // A stalled character and its end-of-run flag must hold until taken.
   `B32SE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol) && $stable(rsp_run_last), "stalled item changed")

   `B32SE_ASSERT_IMP(a_symbol_set, rsp_valid, is_letter || is_digit || is_newline, "character outside the alphabet")

   // A newline always closes the run of the byte that caused it.
   `B32SE_ASSERT_IMP(a_newline_last, rsp_valid && is_newline, rsp_run_last, "newline not last in run")

   // The input side only stalls while both result slots hold unfinished runs.
   `B32SE_ASSERT_IMP(a_stall_busy, req_valid && !req_ready, rsp_valid, "input stalled with no output pending")

endmodule

bind base32_stream_encoder b32se_checker u_b32se_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_symbol   (rsp_if.symbol),
   .rsp_run_last (rsp_if.run_last)
);
